// ===== sv/lsi2c_pkg.sv =====
package lsi2c_pkg;

  // Operation kinds of the pin sequencer program.
  typedef enum logic [3:0] {
    K_END,
    K_REL,
    K_START,
    K_SENDW,
    K_SENDR,
    K_SENDM,
    K_RACK,
    K_WAIT,
    K_SDA1,
    K_RECVH,
    K_RECVL,
    K_ACK0,
    K_ACK1,
    K_STOP
  } kind_t;

  typedef logic [4:0] phase_t;

  localparam phase_t PH_IDLE        = 5'd0;
  localparam phase_t PH_WRITE_ENTRY = 5'd1;
  localparam phase_t PH_READ_ENTRY  = 5'd9;

  // Command codes carried in func.
  localparam logic [1:0] FUNC_NONE     = 2'd0;
  localparam logic [1:0] FUNC_SET_MODE = 2'd1;
  localparam logic [1:0] FUNC_READ     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_UNIT      = 2'd1;
  localparam logic [1:0] CFG_WAIT_HIGH = 2'd2;
  localparam logic [1:0] CFG_WAIT_LOW  = 2'd3;

  // Configuration reset values.
  localparam logic [6:0]  DEV_ADDR_RST  = 7'd35;
  localparam logic [15:0] UNIT_RST      = 16'd1;
  localparam logic [15:0] WAIT_HIGH_RST = 16'd150;
  localparam logic [15:0] WAIT_LOW_RST  = 16'd20;

  // Sensor mode codes that need a conversion wait.
  localparam logic [7:0] MODE_CONT_H1 = 8'h10;
  localparam logic [7:0] MODE_CONT_H2 = 8'h11;
  localparam logic [7:0] MODE_CONT_L  = 8'h13;
  localparam logic [7:0] MODE_ONCE_H1 = 8'h20;
  localparam logic [7:0] MODE_ONCE_H2 = 8'h21;
  localparam logic [7:0] MODE_ONCE_L  = 8'h23;

  // lux = floor(raw * 5 / 6) = (raw * 5 * ceil(2^21 / 6)) >> 21, exact for 16-bit raw.
  localparam int          LUX_SHIFT = 21;
  localparam logic [20:0] LUX_RECIP = 21'd1747630;
  localparam int          LUX_PROD_W = 16 + 21;

  // One input item.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] mode_code;
    logic       sda_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] lux_value;
    logic        nack_seen;
  } res_t;

  // Program of operations, indexed by phase.
  function automatic kind_t prog_kind(input phase_t p);
    kind_t k;
    case (p)
      5'd1:    k = K_REL;
      5'd2:    k = K_START;
      5'd3:    k = K_SENDW;
      5'd4:    k = K_RACK;
      5'd5:    k = K_SENDM;
      5'd6:    k = K_RACK;
      5'd7:    k = K_STOP;
      5'd9:    k = K_WAIT;
      5'd10:   k = K_START;
      5'd11:   k = K_SENDR;
      5'd12:   k = K_RACK;
      5'd13:   k = K_SDA1;
      5'd14:   k = K_RECVH;
      5'd15:   k = K_ACK0;
      5'd16:   k = K_SDA1;
      5'd17:   k = K_RECVL;
      5'd18:   k = K_ACK1;
      5'd19:   k = K_STOP;
      default: k = K_END;
    endcase
    return k;
  endfunction

  // Conversion wait in delay units for a mode code.
  function automatic logic [15:0] mode_wait(input logic [7:0] m, input logic [15:0] hi,
                                            input logic [15:0] lo);
    logic [15:0] n;
    n = 16'd0;
    if (m inside {MODE_CONT_H1, MODE_CONT_H2, MODE_ONCE_H1, MODE_ONCE_H2}) begin
      n = hi;
    end else if (m inside {MODE_CONT_L, MODE_ONCE_L}) begin
      n = lo;
    end
    return n;
  endfunction

endpackage

// ===== sv/light_sensor_i2c_master_core.sv =====
// Light sensor I2C master: one tick of the pin sequencer per accepted request.
// Accepted requests wait in an input register; each result is loaded into a result register.
// Throughput: one request per cycle while the result channel does not stall.
// Reset (rst_n low, synchronous): sequencer idle, lines released, lux and nack cleared,
// configuration registers back to their defaults, both channel registers empty.
module light_sensor_i2c_master_core
  import lsi2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // func[1:0], mode_code[9:2], sda_in[10], zeros above
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                   // lux_value[19:4], nack_seen[20], zeros above
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic     in_valid_r, in_valid_nxt;
  in_item_t item_r;
  logic     out_free;
  logic     step_en;
  res_t     res;

  // The sequencer steps when the input register holds a request and the result can go out.
  assign step_en   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step_en;
  assign cfg_ready = 1'b1;

  // Input register.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (step_en) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func      <= in_tdata[1:0];
      item_r.mode_code <= in_tdata[9:2];
      item_r.sda_in    <= in_tdata[10];
    end
  end

  // Sequencer and configuration registers.
  lsi2c_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (step_en),
    .item      (item_r),
    .res       (res)
  );

  // Result register.
  lsi2c_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/lsi2c_seq.sv =====
module lsi2c_seq
  import lsi2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        step_en,
  input  in_item_t    item,
  output res_t        res
);

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  shift;
    logic [15:0] wait_cnt;
  } seg_t;

  // Configuration registers.
  logic [6:0]  dev_addr_r;
  logic [15:0] unit_r;
  logic [15:0] wait_hi_r;
  logic [15:0] wait_lo_r;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [15:0] pre_r, pre_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [15:0] lux_r, lux_nxt;
  logic        nack_r, nack_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        done;

  // Set up a segment; an empty conversion wait is skipped to the next one.
  function automatic seg_t enter_seg(input phase_t p, input logic [7:0] cur_shift,
                                     input logic [15:0] cur_wait, input logic [7:0] mode,
                                     input logic [6:0] addr, input logic [15:0] hi,
                                     input logic [15:0] lo);
    seg_t        s;
    logic [15:0] n;
    s.phase    = p;
    s.shift    = cur_shift;
    s.wait_cnt = cur_wait;
    n          = mode_wait(mode, hi, lo);
    if (prog_kind(p) == K_WAIT && n == 16'd0) begin
      s.phase = p + 5'd1;
    end
    case (prog_kind(s.phase))
      K_SENDW:         s.shift = {addr, 1'b0};
      K_SENDR:         s.shift = {addr, 1'b1};
      K_SENDM:         s.shift = mode;
      K_RECVH, K_RECVL: s.shift = 8'd0;
      K_WAIT:          s.wait_cnt = n;
      default:         ;
    endcase
    return s;
  endfunction

  // Configuration writes take effect at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      unit_r     <= UNIT_RST;
      wait_hi_r  <= WAIT_HIGH_RST;
      wait_lo_r  <= WAIT_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:  dev_addr_r <= cfg_data[6:0];
        CFG_UNIT:      unit_r     <= cfg_data;
        CFG_WAIT_HIGH: wait_hi_r  <= cfg_data;
        CFG_WAIT_LOW:  wait_lo_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // One tick of the sequencer: start, pin operation, unit advance, segment change.
  always_comb begin
    seg_t        seg;
    kind_t       kind;
    logic [15:0] unit;
    logic [16:0] pre_inc;
    logic [2:0]  step_inc;
    logic [2:0]  per;
    logic [2:0]  last_bit;
    logic        seg_done;
    logic [15:0] raw;
    logic [LUX_PROD_W-1:0] prod;

    phase_nxt = phase_r;
    step_nxt  = step_r;
    bit_nxt   = bit_r;
    pre_nxt   = pre_r;
    wait_nxt  = wait_r;
    shift_nxt = shift_r;
    high_nxt  = high_r;
    cmd_nxt   = cmd_r;
    mode_nxt  = mode_r;
    lux_nxt   = lux_r;
    nack_nxt  = nack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    seg       = '0;
    kind      = K_END;
    unit      = 16'd1;
    pre_inc   = 17'd0;
    step_inc  = 3'd0;
    per       = 3'd1;
    last_bit  = 3'd0;
    seg_done  = 1'b0;
    raw       = 16'd0;
    prod      = '0;

    if (step_en) begin
      // A command is taken only while idle.
      if (phase_r == PH_IDLE && (item.func == FUNC_SET_MODE || item.func == FUNC_READ)) begin
        cmd_nxt  = item.func;
        mode_nxt = item.mode_code;
        nack_nxt = 1'b0;
        seg = enter_seg((item.func == FUNC_SET_MODE) ? PH_WRITE_ENTRY : PH_READ_ENTRY,
                        shift_r, wait_r, item.mode_code, dev_addr_r, wait_hi_r, wait_lo_r);
        phase_nxt = seg.phase;
        shift_nxt = seg.shift;
        wait_nxt  = seg.wait_cnt;
        step_nxt  = 2'd0;
        bit_nxt   = 3'd0;
        pre_nxt   = 16'd0;
      end

      if (phase_nxt != PH_IDLE) begin
        kind = prog_kind(phase_nxt);
        unit = (unit_r == 16'd0) ? 16'd1 : unit_r;

        // Pin operation on the first tick of a unit.
        if (pre_nxt == 16'd0) begin
          case (kind)
            K_REL: begin
              scl_nxt = 1'b1;
              sda_nxt = 1'b1;
            end
            K_START: begin
              case (step_nxt)
                2'd0:    sda_nxt = 1'b1;
                2'd1:    scl_nxt = 1'b1;
                2'd2:    sda_nxt = 1'b0;
                default: scl_nxt = 1'b0;
              endcase
            end
            K_SENDW, K_SENDR, K_SENDM: begin
              if (step_nxt == 2'd0) sda_nxt = shift_nxt[3'd7 - bit_nxt];
              else scl_nxt = (step_nxt == 2'd1);
            end
            K_RACK: begin
              case (step_nxt)
                2'd0:    sda_nxt = 1'b1;
                2'd1:    scl_nxt = 1'b1;
                2'd2:    if (item.sda_in) nack_nxt = 1'b1;
                default: scl_nxt = 1'b0;
              endcase
            end
            K_SDA1: sda_nxt = 1'b1;
            K_RECVH, K_RECVL: begin
              if (step_nxt == 2'd0) scl_nxt = 1'b1;
              else if (step_nxt == 2'd1) begin
                if (item.sda_in) shift_nxt[3'd7 - bit_nxt] = 1'b1;
              end else scl_nxt = 1'b0;
            end
            K_ACK0, K_ACK1: begin
              if (step_nxt == 2'd0) sda_nxt = (kind == K_ACK1);
              else scl_nxt = (step_nxt == 2'd1);
            end
            K_STOP: begin
              if (step_nxt == 2'd0) sda_nxt = 1'b0;
              else if (step_nxt == 2'd1) scl_nxt = 1'b1;
              else sda_nxt = 1'b1;
            end
            default: ;
          endcase
        end

        // Delay unit prescaler.
        pre_inc = {1'b0, pre_nxt} + 17'd1;
        if (pre_inc >= {1'b0, unit}) begin
          pre_nxt = 16'd0;
          if (kind == K_WAIT) begin
            if (wait_nxt <= 16'd1) begin
              wait_nxt = 16'd0;
              seg_done = 1'b1;
            end else begin
              wait_nxt = wait_nxt - 16'd1;
            end
          end else begin
            case (kind)
              K_START, K_RACK: begin
                per = 3'd4;
              end
              K_SENDW, K_SENDR, K_SENDM, K_RECVH, K_RECVL: begin
                per      = 3'd3;
                last_bit = 3'd7;
              end
              K_ACK0, K_ACK1, K_STOP: begin
                per = 3'd3;
              end
              default: ;
            endcase
            step_inc = {1'b0, step_nxt} + 3'd1;
            if (step_inc < per) begin
              step_nxt = step_inc[1:0];
            end else begin
              step_nxt = 2'd0;
              if (bit_nxt >= last_bit) seg_done = 1'b1;
              else bit_nxt = bit_nxt + 3'd1;
            end
          end
        end else begin
          pre_nxt = pre_inc[15:0];
        end

        // Segment change, and command end.
        if (seg_done) begin
          if (kind == K_RECVH) high_nxt = shift_nxt;
          seg = enter_seg(phase_nxt + 5'd1, shift_nxt, wait_nxt, mode_nxt, dev_addr_r,
                          wait_hi_r, wait_lo_r);
          phase_nxt = seg.phase;
          shift_nxt = seg.shift;
          wait_nxt  = seg.wait_cnt;
          step_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          pre_nxt   = 16'd0;
          if (prog_kind(phase_nxt) == K_END) begin
            if (cmd_nxt == FUNC_READ) begin
              raw     = {high_nxt, shift_nxt};
              prod    = LUX_PROD_W'(raw) * LUX_PROD_W'(LUX_RECIP);
              lux_nxt = prod[LUX_SHIFT +: 16];
            end
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r  <= 2'd0;
      bit_r   <= 3'd0;
      pre_r   <= 16'd0;
      wait_r  <= 16'd0;
      shift_r <= 8'd0;
      high_r  <= 8'd0;
      cmd_r   <= FUNC_NONE;
      mode_r  <= 8'd0;
      lux_r   <= 16'd0;
      nack_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      bit_r   <= bit_nxt;
      pre_r   <= pre_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      high_r  <= high_nxt;
      cmd_r   <= cmd_nxt;
      mode_r  <= mode_nxt;
      lux_r   <= lux_nxt;
      nack_r  <= nack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  // Result of this tick.
  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.lux_value = lux_nxt;
    res.nack_seen = nack_nxt;
  end

  // An idle sequencer leaves both lines released.
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (scl_r && sda_r))
    else $error("lines not released while idle");

  // An idle sequencer holds its unit counters at zero.
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (step_r == 2'd0 && bit_r == 3'd0 && pre_r == 16'd0))
    else $error("counters not cleared while idle");

  // A finished command leaves the sequencer idle on the next cycle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (phase_r == PH_IDLE))
    else $error("sequencer busy after done");

  // The stored measurement never exceeds the full-scale value.
  a_lux_range: assert property (@(posedge clk) disable iff (!rst_n)
    lux_r <= 16'd54612)
    else $error("lux out of range");

  // A stalled sequencer keeps its phase.
  a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r))
    else $error("phase moved without a request");

endmodule

// ===== sv/lsi2c_out_reg.sv =====
module lsi2c_out_reg
  import lsi2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_t        res,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // The register can take a new result when empty or when it is being drained.
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.nack_seen, res_r.lux_value, res_r.done_res,
                       res_r.busy_res, res_r.sda_out, res_r.scl_out};

endmodule

// ===== tb/light_sensor_i2c_master_core_tb.sv =====
module light_sensor_i2c_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsi2c_pkg::*;

  // Command code that the sequencer treats like no command.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Line and status values that can be read straight off the behavior.
  localparam res_t LINES_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                  done_res: 1'b0, lux_value: 16'd0, nack_seen: 1'b0};
  localparam res_t LINES_REL_BUSY = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                      done_res: 1'b0, lux_value: 16'd0, nack_seen: 1'b0};

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] mode;
    logic       sda;
    logic       fixed;
    res_t       want;
  } warmup_row_t;

  typedef struct {
    logic        write;
    logic [6:0]  addr;
    logic [15:0] unit_ticks;
    logic [15:0] wait_high;
    logic [15:0] wait_low;
    int          budget;
    logic        cut;
    logic        set_only;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  light_sensor_i2c_master_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Register copies and sequencer state of the bus model.
  logic [6:0]  p_addr;
  logic [15:0] p_unit;
  logic [15:0] p_whigh;
  logic [15:0] p_wlow;
  phase_t      s_phase;
  int          s_step;
  int          s_bit;
  int          s_pres;
  int          s_wait;
  logic [7:0]  s_shift;
  logic [7:0]  s_high;
  logic [1:0]  s_cmd;
  logic [7:0]  s_mode;
  logic [15:0] s_lux;
  logic        s_nack;
  logic        s_scl;
  logic        s_sda;

  // Predicted line and status values, oldest first.
  res_t tick_outcomes_q[$];

  int n_mismatch = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_set_started = 0;
  int n_read_started = 0;
  int n_done = 0;
  int n_lux_nonzero = 0;
  int n_nack_done = 0;
  int line_style = 2;
  logic calm_send = 1'b0;

  function automatic kind_t op_at(input phase_t p);
    kind_t k;
    case (p)
      PH_WRITE_ENTRY:     k = K_REL;
      5'd2, 5'd10:        k = K_START;
      5'd3:               k = K_SENDW;
      5'd4, 5'd6, 5'd12:  k = K_RACK;
      5'd5:               k = K_SENDM;
      5'd7, 5'd19:        k = K_STOP;
      PH_READ_ENTRY:      k = K_WAIT;
      5'd11:              k = K_SENDR;
      5'd13, 5'd16:       k = K_SDA1;
      5'd14:              k = K_RECVH;
      5'd15:              k = K_ACK0;
      5'd17:              k = K_RECVL;
      5'd18:              k = K_ACK1;
      default:            k = K_END;
    endcase
    return k;
  endfunction

  // Conversion wait of a mode; modes outside the six known ones read at once.
  function automatic logic [15:0] conversion_units(input logic [7:0] m);
    if (m == MODE_CONT_H1 || m == MODE_CONT_H2 || m == MODE_ONCE_H1 || m == MODE_ONCE_H2) begin
      return p_whigh;
    end else if (m == MODE_CONT_L || m == MODE_ONCE_L) begin
      return p_wlow;
    end
    return 16'd0;
  endfunction

  // Set up the operation at the current phase, stepping over an empty wait.
  function automatic void load_segment();
    logic        again;
    logic [15:0] n;
    s_step = 0;
    s_bit = 0;
    s_pres = 0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (op_at(s_phase))
        K_SENDW: s_shift = {p_addr, 1'b0};
        K_SENDR: s_shift = {p_addr, 1'b1};
        K_SENDM: s_shift = s_mode;
        K_RECVH, K_RECVL: s_shift = 8'd0;
        K_WAIT: begin
          n = conversion_units(s_mode);
          if (n == 16'd0) begin
            s_phase = s_phase + 1'b1;
            again = 1'b1;
          end else begin
            s_wait = n;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Pin action on the first tick of a delay unit.
  function automatic void pin_action(input kind_t k, input logic sda_i);
    case (k)
      K_REL: begin
        s_scl = 1'b1;
        s_sda = 1'b1;
      end
      K_START: begin
        case (s_step)
          0: s_sda = 1'b1;
          1: s_scl = 1'b1;
          2: s_sda = 1'b0;
          default: s_scl = 1'b0;
        endcase
      end
      K_SENDW, K_SENDR, K_SENDM: begin
        if (s_step == 0) s_sda = s_shift[7 - s_bit];
        else s_scl = (s_step == 1);
      end
      K_RACK: begin
        case (s_step)
          0: s_sda = 1'b1;
          1: s_scl = 1'b1;
          2: if (sda_i) s_nack = 1'b1;
          default: s_scl = 1'b0;
        endcase
      end
      K_SDA1: s_sda = 1'b1;
      K_RECVH, K_RECVL: begin
        case (s_step)
          0: s_scl = 1'b1;
          1: if (sda_i) s_shift[7 - s_bit] = 1'b1;
          default: s_scl = 1'b0;
        endcase
      end
      K_ACK0, K_ACK1: begin
        if (s_step == 0) s_sda = (k == K_ACK1);
        else s_scl = (s_step == 1);
      end
      K_STOP: begin
        case (s_step)
          0: s_sda = 1'b0;
          1: s_scl = 1'b1;
          default: s_sda = 1'b1;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Close one delay unit; true once the whole operation has finished.
  function automatic logic unit_closes_op(input kind_t k);
    int per;
    int bits;
    per = 1;
    bits = 1;
    if (k == K_WAIT) begin
      if (s_wait <= 1) begin
        s_wait = 0;
        return 1'b1;
      end
      s_wait--;
      return 1'b0;
    end
    case (k)
      K_START, K_RACK: per = 4;
      K_SENDW, K_SENDR, K_SENDM, K_RECVH, K_RECVL: begin
        per = 3;
        bits = 8;
      end
      K_ACK0, K_ACK1, K_STOP: per = 3;
      default: ;
    endcase
    s_step++;
    if (s_step < per) return 1'b0;
    s_step = 0;
    if (s_bit + 1 >= bits) return 1'b1;
    s_bit++;
    return 1'b0;
  endfunction

  // One clock tick of the sequencer: line drives and status after the tick.
  function automatic res_t bus_tick(input in_item_t it);
    kind_t       k;
    int          unit_len;
    int unsigned raw;
    logic        done;
    res_t        r;
    done = 1'b0;
    if (s_phase == PH_IDLE && (it.func == FUNC_SET_MODE || it.func == FUNC_READ)) begin
      s_cmd = it.func;
      s_mode = it.mode_code;
      s_nack = 1'b0;
      if (it.func == FUNC_SET_MODE) begin
        s_phase = PH_WRITE_ENTRY;
        n_set_started++;
      end else begin
        s_phase = PH_READ_ENTRY;
        n_read_started++;
      end
      load_segment();
    end
    if (s_phase != PH_IDLE) begin
      k = op_at(s_phase);
      unit_len = (p_unit == 16'd0) ? 1 : int'(p_unit);
      if (s_pres == 0) pin_action(k, it.sda_in);
      s_pres++;
      if (s_pres >= unit_len) begin
        s_pres = 0;
        if (unit_closes_op(k)) begin
          if (k == K_RECVH) s_high = s_shift;
          s_phase = s_phase + 1'b1;
          load_segment();
          if (op_at(s_phase) == K_END) begin
            if (s_cmd == FUNC_READ) begin
              raw = {s_high, s_shift};
              s_lux = 16'((raw * 5) / 6);
              if (s_lux != 16'd0) n_lux_nonzero++;
            end
            if (s_nack) n_nack_done++;
            s_phase = PH_IDLE;
            s_step = 0;
            s_bit = 0;
            done = 1'b1;
            n_done++;
          end
        end
      end
    end
    r.scl_out = s_scl;
    r.sda_out = s_sda;
    r.busy_res = (s_phase != PH_IDLE);
    r.done_res = done;
    r.lux_value = s_lux;
    r.nack_seen = s_nack;
    return r;
  endfunction

  function automatic logic pick_sda();
    case (line_style)
      0: return 1'b0;
      1: return 1'b1;
      2: return 1'($urandom_range(0, 1));
      default: return ($urandom_range(0, 7) == 0);
    endcase
  endfunction

  function automatic logic [7:0] pick_mode();
    case ($urandom_range(0, 9))
      0: return MODE_CONT_H1;
      1: return MODE_CONT_H2;
      2: return MODE_CONT_L;
      3: return MODE_ONCE_H1;
      4: return MODE_ONCE_H2;
      5: return MODE_ONCE_L;
      6: return 8'h00;
      7: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    n_mismatch++;
    if (n_mismatch <= 40) begin
      $display("tick %0d: %s is 0x%0h, expected 0x%0h", n_checked, field, got, want);
    end
  endtask

  // Offer one tick request after a random gap; predict it once accepted.
  task automatic send_tick(input logic [1:0] func, input logic [7:0] mode, input logic sda,
                           input logic fixed, input res_t fixed_want);
    int       gap;
    in_item_t it;
    res_t     predicted;
    if ($urandom_range(0, 39) == 0) calm_send = ~calm_send;
    gap = calm_send ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = func;
    it.mode_code = mode;
    it.sda_in = sda;
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, sda, mode, func};
    do @(posedge clk); while (!in_tready);
    predicted = bus_tick(it);
    tick_outcomes_q.push_back(fixed ? fixed_want : predicted);
    n_sent++;
  endtask

  // Write one register; the caller lowers cfg_valid after its last write.
  task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEV_ADDR:  p_addr = val[6:0];
      CFG_UNIT:      p_unit = val;
      CFG_WAIT_HIGH: p_whigh = val;
      CFG_WAIT_LOW:  p_wlow = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (tick_outcomes_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: checks each result against the oldest prediction and stalls at random.
  initial begin
    res_t got;
    res_t want;
    int   stall_left;
    int   hold_left;
    logic held;
    logic calm_recv;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    calm_recv = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.scl_out = out_tdata[0];
        got.sda_out = out_tdata[1];
        got.busy_res = out_tdata[2];
        got.done_res = out_tdata[3];
        got.lux_value = out_tdata[19:4];
        got.nack_seen = out_tdata[20];
        if (tick_outcomes_q.size() == 0) begin
          report_mismatch("result with no request pending", out_tdata, 0);
        end else begin
          want = tick_outcomes_q.pop_front();
          if (got.scl_out != want.scl_out) report_mismatch("scl_out", got.scl_out, want.scl_out);
          if (got.sda_out != want.sda_out) report_mismatch("sda_out", got.sda_out, want.sda_out);
          if (got.busy_res != want.busy_res) begin
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          end
          if (got.done_res != want.done_res) begin
            report_mismatch("done_res", got.done_res, want.done_res);
          end
          if (got.lux_value != want.lux_value) begin
            report_mismatch("lux_value", got.lux_value, want.lux_value);
          end
          if (got.nack_seen != want.nack_seen) begin
            report_mismatch("nack_seen", got.nack_seen, want.nack_seen);
          end
        end
        n_checked++;
        if ($urandom_range(0, 39) == 0) calm_recv = ~calm_recv;
        stall_left = calm_recv ? 0 : $urandom_range(0, 13);
      end
      // One long hold-off so that the block fills up and stops taking requests.
      if (!held && n_checked >= 300) begin
        held = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: warm-up table, then command sequences under several register settings.
  initial begin
    warmup_row_t warmup_tab [24];
    setting_t    plan [7];
    int          ticks;
    logic [1:0]  func;

    in_tvalid <= 1'b0;
    in_tdata <= 16'd0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data <= 16'd0;
    rst_n <= 1'b0;

    p_addr = DEV_ADDR_RST;
    p_unit = UNIT_RST;
    p_whigh = WAIT_HIGH_RST;
    p_wlow = WAIT_LOW_RST;
    s_phase = PH_IDLE;
    s_step = 0;
    s_bit = 0;
    s_pres = 0;
    s_wait = 0;
    s_shift = 8'd0;
    s_high = 8'd0;
    s_cmd = FUNC_NONE;
    s_mode = 8'd0;
    s_lux = 16'd0;
    s_nack = 1'b0;
    s_scl = 1'b1;
    s_sda = 1'b1;

    // Idle ticks, a set-mode start, requests while busy, then part of the address byte.
    warmup_tab = '{
      '{FUNC_NONE,     8'h00, 1'b0, 1'b1, LINES_IDLE},
      '{FUNC_UNUSED,   8'hFF, 1'b1, 1'b1, LINES_IDLE},
      '{FUNC_UNUSED,   8'h00, 1'b0, 1'b1, LINES_IDLE},
      '{FUNC_NONE,     8'hFF, 1'b1, 1'b1, LINES_IDLE},
      '{FUNC_SET_MODE, 8'hFF, 1'b0, 1'b1, LINES_REL_BUSY},
      '{FUNC_READ,     8'h10, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_SET_MODE, 8'h00, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_UNUSED,   8'hAA, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_READ,     8'h55, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h01, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h02, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h04, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h08, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h10, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h20, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h40, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h80, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_READ,     8'h23, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h7F, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'hFE, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_SET_MODE, 8'hC3, 1'b0, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h3C, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'h00, 1'b1, 1'b0, LINES_IDLE},
      '{FUNC_NONE,     8'hFF, 1'b0, 1'b0, LINES_IDLE}
    };

    // Register settings per run segment. A cut segment stops at its budget even in mid-command, so the
    // next segment's writes can land while a command is still under way.
    plan = '{
      '{1'b0, 7'd35,  16'd1,     16'd150,   16'd20,    200, 1'b0, 1'b0},
      '{1'b1, 7'd0,   16'd0,     16'd0,     16'd0,     220, 1'b0, 1'b0},
      '{1'b1, 7'd127, 16'd2,     16'd3,     16'd5,     260, 1'b1, 1'b0},
      '{1'b1, 7'd85,  16'd3,     16'd1,     16'd2,     100, 1'b0, 1'b0},
      '{1'b1, 7'd42,  16'd65535, 16'd65535, 16'd65535, 30,  1'b1, 1'b1},
      '{1'b1, 7'd99,  16'd1,     16'd2,     16'd1,     260, 1'b0, 1'b0},
      '{1'b1, 7'd0,   16'd1,     16'd0,     16'd0,     260, 1'b0, 1'b0}
    };
    plan[6].addr = 7'($urandom);
    plan[6].wait_high = 16'($urandom_range(0, 8));
    plan[6].wait_low = 16'($urandom_range(0, 8));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 7; p++) begin
      if (plan[p].write) begin
        drain_results();
        cfg_put(CFG_DEV_ADDR, {9'd0, plan[p].addr});
        cfg_put(CFG_UNIT, plan[p].unit_ticks);
        cfg_put(CFG_WAIT_HIGH, plan[p].wait_high);
        cfg_put(CFG_WAIT_LOW, plan[p].wait_low);
        cfg_valid <= 1'b0;
      end
      if (p == 0) begin
        foreach (warmup_tab[i]) begin
          send_tick(warmup_tab[i].func, warmup_tab[i].mode, warmup_tab[i].sda,
                    warmup_tab[i].fixed, warmup_tab[i].want);
        end
      end
      ticks = 0;
      while (ticks < plan[p].budget || (!plan[p].cut && s_phase != PH_IDLE)) begin
        if (s_phase != PH_IDLE) begin
          // Mid-command: mostly plain ticks, now and then a request that must be ignored.
          func = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : FUNC_NONE;
          send_tick(func, 8'($urandom), pick_sda(), 1'b0, LINES_IDLE);
        end else if ($urandom_range(0, 7) == 0) begin
          func = $urandom_range(0, 1) ? FUNC_NONE : FUNC_UNUSED;
          send_tick(func, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, LINES_IDLE);
        end else begin
          // New command with its own pattern on the data line.
          line_style = $urandom_range(0, 3);
          func = (plan[p].set_only || $urandom_range(0, 4) < 2) ? FUNC_SET_MODE : FUNC_READ;
          send_tick(func, pick_mode(), pick_sda(), 1'b0, LINES_IDLE);
        end
        ticks++;
      end
      in_tvalid <= 1'b0;
    end

    drain_results();
    $display("Ran %0d sequencer ticks over 7 register settings: %0d set-mode and %0d read",
             n_sent, n_set_started, n_read_started);
    $display("commands started, %0d finished, %0d nonzero lux readings, %0d with a nack.",
             n_done, n_lux_nonzero, n_nack_done);
    if (n_mismatch == 0) begin
      $display("light_sensor_i2c_master_core_tb passed");
    end else begin
      $display("light_sensor_i2c_master_core_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("light_sensor_i2c_master_core_tb failed");
    $finish;
  end

endmodule

// ===== light_sensor_i2c_master_core.f =====
sv/lsi2c_pkg.sv
sv/lsi2c_seq.sv
sv/lsi2c_out_reg.sv
sv/light_sensor_i2c_master_core.sv
tb/light_sensor_i2c_master_core_tb.sv
